// ===== rtl/tpc_pkg.sv =====
// Shared constants, types and helpers for the touch point conditioner.
// Used by tpc_scale and touch_point_conditioner; depends on nothing.
package tpc_pkg;

  localparam int RELEASE_POLLS_DEF = 6;
  localparam int SCREEN_BITS_DEF   = 11;
  localparam int COORD_MAX_BITS    = 12;
  localparam int RAW_BITS          = 12;
  localparam int OUT_BITS          = 11;
  localparam int CFG_BITS          = 12;
  localparam int CFG_INDEX_BITS    = 3;
  localparam int COUNT_BITS        = 4;
  localparam int QUOT_LOSS         = 7;

  localparam logic [CFG_INDEX_BITS-1:0] REG_SWAP_AXES     = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FLIP_X        = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FLIP_Y        = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SCREEN_WIDTH  = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SCREEN_HEIGHT = 3'd4;

  localparam logic [CFG_BITS-1:0] WIDTH_RESET  = 12'd320;
  localparam logic [CFG_BITS-1:0] HEIGHT_RESET = 12'd240;

  localparam int RAW_X_LO = 22;
  localparam int RAW_X_HI = 288;
  localparam int RAW_Y_LO = 17;
  localparam int RAW_Y_HI = 242;
  localparam int X_SPAN   = RAW_X_HI - RAW_X_LO;
  localparam int Y_SPAN   = RAW_Y_HI - RAW_Y_LO;
  localparam int X_HALF   = X_SPAN / 2;
  localparam int Y_HALF   = Y_SPAN / 2;

  // X: numerator is halved, then divided by span/2 (odd) via reciprocal
  localparam int X_DIV          = X_SPAN / 2;
  localparam int RECIP_X_SHIFT  = 31;
  localparam longint unsigned RECIP_X =
    ((64'd1 << RECIP_X_SHIFT) + 64'(X_DIV) - 64'd1) / 64'(X_DIV);
  localparam int RECIP_Y_SHIFT  = 32;
  localparam longint unsigned RECIP_Y =
    ((64'd1 << RECIP_Y_SHIFT) + 64'(Y_SPAN) - 64'd1) / 64'(Y_SPAN);

  typedef struct packed {
    logic valid;
    logic press;
  } stage_ctl_t;

  function automatic logic [COORD_MAX_BITS-1:0] median3(
    input logic [COORD_MAX_BITS-1:0] a,
    input logic [COORD_MAX_BITS-1:0] b,
    input logic [COORD_MAX_BITS-1:0] c
  );
    logic [COORD_MAX_BITS-1:0] lo;
    logic [COORD_MAX_BITS-1:0] hi;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    if (c < lo) begin
      return lo;
    end else if (c > hi) begin
      return hi;
    end
    return c;
  endfunction

endpackage

// ===== rtl/touch_point_conditioner.sv =====
// Top level: config registers, clamp, 3-point median filter, release hold.
// Depends on tpc_pkg and tpc_scale.
//
//   channel  handshake                 payload
//   poll     poll_valid / poll_stall   status_byte x_high y_high low_nibbles
//   point    point_valid / point_stall screen_x screen_y touch_active
//   cfg      cfg_valid / cfg_ready     cfg_index cfg_data
//
// One request per cycle in, one point per cycle out while point_stall is low;
// the stages: input reg, calibration multiply, reciprocal divide, filter/result reg.
// Filter state lives in the last stage, so each point sees the one before.
// Synchronous reset clears valids, filter/hold state and config defaults.
// A stalled point holds; requests keep flowing until the pipe is full.
module touch_point_conditioner #(
  parameter int RELEASE_POLLS = tpc_pkg::RELEASE_POLLS_DEF,
  parameter int SCREEN_BITS   = tpc_pkg::SCREEN_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                poll_valid,
  output logic                                poll_stall,
  input  logic [7:0]                          status_byte,
  input  logic [7:0]                          x_high,
  input  logic [7:0]                          y_high,
  input  logic [7:0]                          low_nibbles,
  output logic                                point_valid,
  input  logic                                point_stall,
  output logic [tpc_pkg::OUT_BITS-1:0]        screen_x,
  output logic [tpc_pkg::OUT_BITS-1:0]        screen_y,
  output logic                                touch_active,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [tpc_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [tpc_pkg::CFG_BITS-1:0]        cfg_data
);

  localparam int OUT_BITS   = tpc_pkg::OUT_BITS;
  localparam int CFG_BITS   = tpc_pkg::CFG_BITS;
  localparam int CMAX       = tpc_pkg::COORD_MAX_BITS;
  localparam int CW         = tpc_pkg::COUNT_BITS;
  localparam int QW         = tpc_pkg::RAW_BITS + SCREEN_BITS - tpc_pkg::QUOT_LOSS;
  localparam int TOP        = 1 << SCREEN_BITS;
  localparam logic [CW-1:0] HOLD = CW'(RELEASE_POLLS);

  logic                swap_axes;
  logic                flip_x;
  logic                flip_y;
  logic [CFG_BITS-1:0] screen_width;
  logic [CFG_BITS-1:0] screen_height;

  logic [SCREEN_BITS-1:0] lim_x;
  logic [SCREEN_BITS-1:0] lim_y;

  tpc_pkg::stage_ctl_t    c_ctl;
  logic [QW-1:0]          qx;
  logic [QW-1:0]          qy;
  logic                   drain;
  logic                   take;

  logic [SCREEN_BITS-1:0] hist_x [3];
  logic [SCREEN_BITS-1:0] hist_y [3];
  logic [1:0]             slot;
  logic                   primed;
  logic [CW-1:0]          release_count;
  logic [SCREEN_BITS-1:0] last_x;
  logic [SCREEN_BITS-1:0] last_y;
  logic [SCREEN_BITS-1:0] out_x;
  logic [SCREEN_BITS-1:0] out_y;
  logic                   out_active;

  logic [SCREEN_BITS-1:0] clamp_x;
  logic [SCREEN_BITS-1:0] clamp_y;
  logic [CW-1:0]          count_next;
  logic                   active;
  logic [SCREEN_BITS-1:0] px;
  logic [SCREEN_BITS-1:0] py;
  logic [1:0]             slot_use;
  logic [1:0]             slot_next;
  logic [SCREEN_BITS-1:0] hist_x_next [3];
  logic [SCREEN_BITS-1:0] hist_y_next [3];
  logic [SCREEN_BITS-1:0] med_x;
  logic [SCREEN_BITS-1:0] med_y;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      swap_axes     <= 1'b0;
      flip_x        <= 1'b0;
      flip_y        <= 1'b0;
      screen_width  <= tpc_pkg::WIDTH_RESET;
      screen_height <= tpc_pkg::HEIGHT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        tpc_pkg::REG_SWAP_AXES:     swap_axes     <= cfg_data[0];
        tpc_pkg::REG_FLIP_X:        flip_x        <= cfg_data[0];
        tpc_pkg::REG_FLIP_Y:        flip_y        <= cfg_data[0];
        tpc_pkg::REG_SCREEN_WIDTH:  screen_width  <= cfg_data;
        tpc_pkg::REG_SCREEN_HEIGHT: screen_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // largest coordinate per axis: size 0 acts as 1, size capped at 2^SCREEN_BITS
  always_comb begin
    if (screen_width == '0) begin
      lim_x = '0;
    end else if ({1'b0, screen_width} > (CFG_BITS+1)'(TOP)) begin
      lim_x = '1;
    end else begin
      lim_x = SCREEN_BITS'(screen_width - 1'b1);
    end
    if (screen_height == '0) begin
      lim_y = '0;
    end else if ({1'b0, screen_height} > (CFG_BITS+1)'(TOP)) begin
      lim_y = '1;
    end else begin
      lim_y = SCREEN_BITS'(screen_height - 1'b1);
    end
  end

  tpc_scale #(
    .SCREEN_BITS (SCREEN_BITS)
  ) u_scale (
    .clk         (clk),
    .rst         (rst),
    .poll_valid  (poll_valid),
    .poll_stall  (poll_stall),
    .status_byte (status_byte),
    .x_high      (x_high),
    .y_high      (y_high),
    .low_nibbles (low_nibbles),
    .swap_axes   (swap_axes),
    .flip_x      (flip_x),
    .flip_y      (flip_y),
    .lim_x       (lim_x),
    .lim_y       (lim_y),
    .drain       (drain),
    .c_ctl       (c_ctl),
    .qx          (qx),
    .qy          (qy)
  );

  assign drain = !point_valid || !point_stall;
  assign take  = c_ctl.valid && drain;

  always_comb begin
    clamp_x = (qx > QW'(lim_x)) ? lim_x : qx[SCREEN_BITS-1:0];
    clamp_y = (qy > QW'(lim_y)) ? lim_y : qy[SCREEN_BITS-1:0];
    count_next = (release_count < HOLD) ? release_count + 1'b1 : release_count;
    active = c_ctl.press || (count_next < HOLD);
    px = c_ctl.press ? clamp_x : last_x;
    py = c_ctl.press ? clamp_y : last_y;
    slot_use  = (primed && slot != 2'd3) ? slot : 2'd0;
    slot_next = (slot_use == 2'd2) ? 2'd0 : slot_use + 1'b1;
    for (int i = 0; i < 3; i++) begin
      hist_x_next[i] = primed ? hist_x[i] : px;
      hist_y_next[i] = primed ? hist_y[i] : py;
    end
    hist_x_next[slot_use] = px;
    hist_y_next[slot_use] = py;
    med_x = SCREEN_BITS'(tpc_pkg::median3(CMAX'(hist_x_next[0]), CMAX'(hist_x_next[1]),
                                          CMAX'(hist_x_next[2])));
    med_y = SCREEN_BITS'(tpc_pkg::median3(CMAX'(hist_y_next[0]), CMAX'(hist_y_next[1]),
                                          CMAX'(hist_y_next[2])));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      point_valid   <= 1'b0;
      slot          <= 2'd0;
      primed        <= 1'b0;
      release_count <= '0;
      last_x        <= '0;
      last_y        <= '0;
    end else begin
      if (drain) begin
        point_valid <= c_ctl.valid;
      end
      if (take) begin
        release_count <= c_ctl.press ? '0 : count_next;
        if (active) begin
          slot   <= slot_next;
          primed <= 1'b1;
          last_x <= med_x;
          last_y <= med_y;
        end else begin
          primed <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_active <= active;
      if (active) begin
        hist_x <= hist_x_next;
        hist_y <= hist_y_next;
        out_x  <= med_x;
        out_y  <= med_y;
      end else begin
        out_x  <= last_x;
        out_y  <= last_y;
      end
    end
  end

  assign screen_x     = OUT_BITS'(out_x);
  assign screen_y     = OUT_BITS'(out_y);
  assign touch_active = out_active;

`ifndef SYNTHESIS
  hold_count_bound: assert property (@(posedge clk) disable iff (rst)
    release_count <= HOLD)
    else $error("release hold count past limit");

  slot_range: assert property (@(posedge clk) disable iff (rst)
    slot != 2'd3)
    else $error("history slot out of range");

  idle_unprimed: assert property (@(posedge clk) disable iff (rst)
    point_valid && !touch_active |-> !primed)
    else $error("filter still primed after release result");

  press_resets_hold: assert property (@(posedge clk) disable iff (rst)
    take && c_ctl.press |=> release_count == '0 && primed)
    else $error("press did not restart hold and filter");
`endif

endmodule

// ===== rtl/tpc_scale.sv =====
// Front pipeline: input register, calibration multiply, reciprocal divide.
// Depends on tpc_pkg; feeds the filter stage in touch_point_conditioner.
module tpc_scale #(
  parameter int SCREEN_BITS = tpc_pkg::SCREEN_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   poll_valid,
  output logic                   poll_stall,
  input  logic [7:0]             status_byte,
  input  logic [7:0]             x_high,
  input  logic [7:0]             y_high,
  input  logic [7:0]             low_nibbles,
  input  logic                   swap_axes,
  input  logic                   flip_x,
  input  logic                   flip_y,
  input  logic [SCREEN_BITS-1:0] lim_x,
  input  logic [SCREEN_BITS-1:0] lim_y,
  input  logic                   drain,
  output tpc_pkg::stage_ctl_t    c_ctl,
  output logic [tpc_pkg::RAW_BITS+SCREEN_BITS-tpc_pkg::QUOT_LOSS-1:0] qx,
  output logic [tpc_pkg::RAW_BITS+SCREEN_BITS-tpc_pkg::QUOT_LOSS-1:0] qy
);

  localparam int RAW_BITS = tpc_pkg::RAW_BITS;
  localparam int NUMW     = RAW_BITS + SCREEN_BITS;
  localparam int QW       = NUMW - tpc_pkg::QUOT_LOSS;
  localparam int PW       = NUMW + 25;
  localparam int DW       = RAW_BITS + 1;

  logic                a_valid;
  logic                a_press;
  logic [RAW_BITS-1:0] a_rx;
  logic [RAW_BITS-1:0] a_ry;
  logic                b_valid;
  logic                b_press;
  logic [NUMW-1:0]     num_x;
  logic [NUMW-1:0]     num_y;
  logic                c_valid;
  logic                c_press;
  logic                b_open;
  logic                c_open;

  logic [RAW_BITS-1:0] sx;
  logic [RAW_BITS-1:0] sy;
  logic signed [DW-1:0] dx;
  logic signed [DW-1:0] dy;
  logic [RAW_BITS-1:0] dxc;
  logic [RAW_BITS-1:0] dyc;
  logic [NUMW-1:0]     num_x_next;
  logic [NUMW-1:0]     num_y_next;
  logic [PW-1:0]       prod_x;
  logic [PW-1:0]       prod_y;

  assign c_open     = !c_valid || drain;
  assign b_open     = !b_valid || c_open;
  assign poll_stall = a_valid && !b_open;

  always_comb begin
    sx = swap_axes ? a_ry : a_rx;
    sy = swap_axes ? a_rx : a_ry;
    dx = flip_x ? (DW'(tpc_pkg::RAW_X_HI) - $signed({1'b0, sx}))
                : ($signed({1'b0, sx}) - DW'(tpc_pkg::RAW_X_LO));
    dy = flip_y ? (DW'(tpc_pkg::RAW_Y_HI) - $signed({1'b0, sy}))
                : ($signed({1'b0, sy}) - DW'(tpc_pkg::RAW_Y_LO));
    // below the calibration floor the scaled value always lands on 0
    dxc = dx[DW-1] ? '0 : dx[RAW_BITS-1:0];
    dyc = dy[DW-1] ? '0 : dy[RAW_BITS-1:0];
    num_x_next = NUMW'(dxc) * NUMW'(lim_x) + NUMW'(tpc_pkg::X_HALF);
    num_y_next = NUMW'(dyc) * NUMW'(lim_y) + NUMW'(tpc_pkg::Y_HALF);
    prod_x = PW'(num_x[NUMW-1:1]) * PW'(tpc_pkg::RECIP_X);
    prod_y = PW'(num_y) * PW'(tpc_pkg::RECIP_Y);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
    end else begin
      if (!a_valid || b_open) begin
        a_valid <= poll_valid;
      end
      if (b_open) begin
        b_valid <= a_valid;
      end
      if (c_open) begin
        c_valid <= b_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (poll_valid && !poll_stall) begin
      a_press <= (status_byte[3:0] != 4'd0);
      a_rx    <= {x_high, low_nibbles[3:0]};
      a_ry    <= {y_high, low_nibbles[7:4]};
    end
    if (b_open) begin
      b_press <= a_press;
      num_x   <= num_x_next;
      num_y   <= num_y_next;
    end
    if (c_open) begin
      c_press <= b_press;
      qx      <= prod_x[tpc_pkg::RECIP_X_SHIFT +: QW];
      qy      <= prod_y[tpc_pkg::RECIP_Y_SHIFT +: QW];
    end
  end

  assign c_ctl.valid = c_valid;
  assign c_ctl.press = c_press;

endmodule
